### hw/rtl/gww_pkg.sv
package gww_pkg;

  localparam int MAX_WORD = 30;
  localparam int IDX_W    = $clog2(MAX_WORD);
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int CH_W     = 8;
  localparam int GW_W     = 6;
  localparam int LW_W     = 12;
  localparam int TRK_W    = 4;
  localparam int SPW_W    = 6;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 2;
  // widest run of a full word: every glyph and every gap at its maximum
  localparam int ACC_W    = $clog2(MAX_WORD * 63 + (MAX_WORD - 1) * 15 + 1);
  localparam int SUM_W    = 14;
  localparam int RAM_W    = CH_W + GW_W;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CH_W-1:0] CH_NONE    = 8'd0;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_EOL   = 1'b1;
  localparam logic CMD_EOT    = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TRACKING    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SPACE_WIDTH = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_SPACE,
    OP_NEWLINE,
    OP_EOT
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] ch;
    logic [GW_W-1:0] gw;
  } item_t;

  typedef struct packed {
    logic            push;
    logic            fin;
    logic            kind;
    logic [CH_W-1:0] ch;
    logic            drop;
  } res_req_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MRD,
    B_MACC,
    B_DECIDE,
    B_SPACE,
    B_ERD,
    B_EWR,
    B_EOLB,
    B_EOLJ,
    B_PARA,
    B_FIN
  } bst_e;

endpackage

### hw/rtl/gww_ram.sv
module gww_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gww_front.sv
module gww_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  output gww_pkg::item_t        item_o,
  output logic                  item_valid_o,
  input  logic                  pop_i
);
  import gww_pkg::*;

  item_t              q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  item_t              in_item;
  logic               push, pop;

  // classify the beat
  always_comb begin
    in_item.ch = s_axis_tdata[CH_W-1:0];
    in_item.gw = s_axis_tdata[CH_W+GW_W-1:CH_W];
    if (s_axis_tuser == CMD_EOT) begin
      in_item.op = OP_EOT;
    end else if (in_item.ch == CH_SPACE) begin
      in_item.op = OP_SPACE;
    end else if (in_item.ch == CH_NEWLINE) begin
      in_item.op = OP_NEWLINE;
    end else begin
      in_item.op = OP_CHAR;
    end
  end

  assign s_axis_tready = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != '0);
  assign pop           = pop_i && item_valid_o;
  assign item_o        = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? Q_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? Q_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = Q_CNT_W'(cnt_q + Q_CNT_W'(push) - Q_CNT_W'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

### hw/rtl/gww_back.sv
module gww_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gww_pkg::item_t            item_i,
  input  logic                      item_valid_i,
  output logic                      pop_o,
  input  logic [gww_pkg::LW_W-1:0]  line_width_i,
  input  logic [gww_pkg::TRK_W-1:0] tracking_i,
  input  logic [gww_pkg::SPW_W-1:0] space_width_i,
  output gww_pkg::res_req_t         req_o,
  input  logic                      rdy_i
);
  import gww_pkg::*;

  bst_e             st_q, st_d;
  op_e              op_q, op_d;
  logic [LEN_W-1:0] len_q, len_d, s_q, s_d, i_q, i_d, e_q, e_d, cut_q, cut_d;
  logic             ovf_q, ovf_d, nonempty_q, nonempty_d, pe_q, pe_d, ts_q, ts_d;
  logic             drop_q, drop_d, found_q, found_d, brk_q, brk_d;
  logic [LW_W-1:0]  used_q, used_d;
  logic [ACC_W-1:0] w_q, w_d, ww_q, ww_d;

  logic             ram_we, ram_re;
  logic [RAM_W-1:0] ram_rdata;
  logic [GW_W-1:0]  gw_rd;
  logic [CH_W-1:0]  ch_rd;
  logic [SUM_W-1:0] cand_m, cand_j, lw_x;
  logic [LEN_W-1:0] i_inc;

  gww_ram #(
    .Width(RAM_W),
    .Depth(MAX_WORD)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(len_q[IDX_W-1:0]),
    .wdata_i({item_i.ch, item_i.gw}),
    .re_i   (ram_re),
    .raddr_i(i_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign gw_rd = ram_rdata[GW_W-1:0];
  assign ch_rd = ram_rdata[RAM_W-1:GW_W];
  assign lw_x  = SUM_W'(line_width_i);
  assign i_inc = LEN_W'(i_q + 1'b1);

  always_comb begin
    if (i_q == s_q) begin
      cand_m = SUM_W'(gw_rd);
    end else begin
      cand_m = SUM_W'(w_q) + SUM_W'(tracking_i) + SUM_W'(gw_rd);
    end
    cand_j = SUM_W'(used_q) + SUM_W'(tracking_i) + SUM_W'(space_width_i)
           + SUM_W'(tracking_i) + SUM_W'(ww_q);
  end

  // next state and datapath
  always_comb begin
    st_d       = st_q;
    op_d       = op_q;
    len_d      = len_q;
    s_d        = s_q;
    i_d        = i_q;
    e_d        = e_q;
    cut_d      = cut_q;
    ovf_d      = ovf_q;
    nonempty_d = nonempty_q;
    pe_d       = pe_q;
    ts_d       = ts_q;
    drop_d     = drop_q;
    found_d    = found_q;
    brk_d      = brk_q;
    used_d     = used_q;
    w_d        = w_q;
    ww_d       = ww_q;
    case (st_q)
      B_IDLE: begin
        if (item_valid_i) begin
          op_d   = item_i.op;
          drop_d = 1'b0;
          if (item_i.op != OP_EOT) begin
            ts_d = 1'b1;
          end
          if (item_i.op == OP_CHAR) begin
            if (len_q < LEN_W'(MAX_WORD)) begin
              len_d = LEN_W'(len_q + 1'b1);
            end else begin
              ovf_d = 1'b1;
            end
          end else if (item_i.op == OP_EOT && !ts_q) begin
            len_d      = '0;
            ovf_d      = 1'b0;
            used_d     = '0;
            nonempty_d = 1'b0;
            pe_d       = 1'b0;
          end else if (len_q != '0) begin
            // place the buffered word first
            drop_d  = ovf_q;
            s_d     = '0;
            i_d     = '0;
            cut_d   = len_q;
            found_d = 1'b0;
            st_d    = B_MRD;
          end else if (item_i.op != OP_SPACE) begin
            st_d = B_PARA;
          end
        end
      end
      B_MRD: st_d = B_MACC;
      B_MACC: begin
        w_d = ACC_W'(cand_m);
        if (!found_q && (i_q != s_q) && (cand_m > lw_x)) begin
          found_d = 1'b1;
          cut_d   = i_q;
        end
        i_d = i_inc;
        if (i_inc == len_q) begin
          ww_d = ACC_W'(cand_m);
          st_d = B_DECIDE;
        end else begin
          st_d = B_MRD;
        end
      end
      B_DECIDE: begin
        i_d = s_q;
        if (!nonempty_q) begin
          if (SUM_W'(ww_q) <= lw_x) begin
            e_d        = len_q;
            brk_d      = 1'b0;
            used_d     = LW_W'(ww_q);
            nonempty_d = 1'b1;
          end else begin
            e_d   = cut_q;
            brk_d = 1'b1;
          end
          st_d = B_ERD;
        end else if (cand_j <= lw_x) begin
          e_d    = len_q;
          brk_d  = 1'b0;
          used_d = LW_W'(cand_j);
          st_d   = B_SPACE;
        end else begin
          st_d = B_EOLJ;
        end
      end
      B_SPACE: begin
        if (rdy_i) begin
          st_d = B_ERD;
        end
      end
      B_ERD: st_d = B_EWR;
      B_EWR: begin
        if (rdy_i) begin
          i_d = i_inc;
          if (i_inc != e_q) begin
            st_d = B_ERD;
          end else if (brk_q) begin
            st_d = B_EOLB;
          end else begin
            len_d = '0;
            ovf_d = 1'b0;
            st_d  = (op_q == OP_SPACE) ? B_FIN : B_PARA;
          end
        end
      end
      B_EOLB: begin
        if (rdy_i) begin
          pe_d = 1'b1;
          if (e_q == len_q) begin
            // last glyph alone was wider than the line: word done
            len_d = '0;
            ovf_d = 1'b0;
            st_d  = (op_q == OP_SPACE) ? B_FIN : B_PARA;
          end else begin
            // remeasure what is left of a hard-broken word
            s_d     = e_q;
            i_d     = e_q;
            cut_d   = len_q;
            found_d = 1'b0;
            st_d    = B_MRD;
          end
        end
      end
      B_EOLJ: begin
        if (rdy_i) begin
          pe_d       = 1'b1;
          nonempty_d = 1'b0;
          used_d     = '0;
          st_d       = B_DECIDE;
        end
      end
      B_PARA: begin
        if (rdy_i) begin
          nonempty_d = 1'b0;
          used_d     = '0;
          pe_d       = 1'b0;
          if (op_q == OP_EOT) begin
            len_d = '0;
            ovf_d = 1'b0;
            ts_d  = 1'b0;
          end
          st_d = B_FIN;
        end
      end
      B_FIN: begin
        if (rdy_i) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o      = (st_q == B_IDLE) && item_valid_i;
    ram_we     = pop_o && (item_i.op == OP_CHAR) && (len_q < LEN_W'(MAX_WORD));
    ram_re     = (st_q == B_MRD) || (st_q == B_ERD);
    req_o.push = 1'b0;
    req_o.fin  = 1'b0;
    req_o.kind = KIND_EOL;
    req_o.ch   = CH_NONE;
    req_o.drop = drop_q;
    case (st_q)
      B_SPACE: begin
        req_o.push = 1'b1;
        req_o.kind = KIND_GLYPH;
        req_o.ch   = CH_SPACE;
      end
      B_EWR: begin
        req_o.push = 1'b1;
        req_o.kind = KIND_GLYPH;
        req_o.ch   = ch_rd;
      end
      B_EOLB, B_EOLJ: req_o.push = 1'b1;
      B_PARA:         req_o.push = nonempty_q || !pe_q;
      B_FIN:          req_o.fin  = 1'b1;
      default:        req_o.push = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= B_IDLE;
      op_q       <= OP_CHAR;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      nonempty_q <= 1'b0;
      pe_q       <= 1'b0;
      ts_q       <= 1'b0;
      used_q     <= '0;
      drop_q     <= 1'b0;
      found_q    <= 1'b0;
      brk_q      <= 1'b0;
    end else begin
      st_q       <= st_d;
      op_q       <= op_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      nonempty_q <= nonempty_d;
      pe_q       <= pe_d;
      ts_q       <= ts_d;
      used_q     <= used_d;
      drop_q     <= drop_d;
      found_q    <= found_d;
      brk_q      <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    i_q   <= i_d;
    e_q   <= e_d;
    cut_q <= cut_d;
    w_q   <= w_d;
    ww_q  <= ww_d;
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_WORD))
    else $error("word length beyond buffer");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_EWR) |-> (i_q < e_q))
    else $error("glyph emit index past end of run");

  a_cut_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_DECIDE && !nonempty_q && SUM_W'(ww_q) > lw_x)
      |-> (cut_q > s_q && cut_q <= len_q))
    else $error("hard break without a valid prefix");

endmodule

### hw/rtl/gww_out.sv
module gww_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gww_pkg::res_req_t  req_i,
  output logic               rdy_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);
  import gww_pkg::*;

  logic            out_v_q, out_v_d, pend_v_q, pend_v_d, move;
  logic            out_kind_q, out_last_q, out_drop_q;
  logic [CH_W-1:0] out_ch_q;
  logic            pend_kind_q, pend_drop_q;
  logic [CH_W-1:0] pend_ch_q;

  // hold one result back so that the final one of an item can carry tlast
  assign rdy_o = !pend_v_q || !out_v_q || m_axis_tready;
  assign move  = pend_v_q && (req_i.push || req_i.fin) && rdy_o;

  always_comb begin
    out_v_d  = out_v_q;
    pend_v_d = pend_v_q;
    if (move) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
    if (req_i.push && rdy_o) begin
      pend_v_d = 1'b1;
    end else if (req_i.fin && rdy_o) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q <= pend_kind_q;
      out_ch_q   <= pend_ch_q;
      out_drop_q <= pend_drop_q;
      out_last_q <= req_i.fin;
    end
    if (req_i.push && rdy_o) begin
      pend_kind_q <= req_i.kind;
      pend_ch_q   <= req_i.ch;
      pend_drop_q <= req_i.drop;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_drop_q, out_ch_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/greedy_word_wrap.sv
// Greedy word wrapper. Characters enter one beat each with their glyph width; a
// separate end-of-text beat closes the text. Word characters enter the word
// buffer while the back end is idle. A space, newline or end of text places
// the buffered word: the back end walks the word buffer (a single-port-read
// RAM) with a read and an accumulate state per character to measure it, then
// with a read and a write state per character to emit the glyphs, and after
// a hard break of a word wider than the line it remeasures the rest. A two-beat
// queue sits between input classification and placement, and a one-result
// hold stage ahead of the output register gives tlast to a beat's final result.
// Configuration must be written while the block is idle.
module greedy_word_wrap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gww_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [gww_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // char_code[7:0], glyph_width[13:8]
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // out_char[7:0], word_dropped[8]
  output logic                          m_axis_tuser,  // kind
  output logic                          m_axis_tlast
);
  import gww_pkg::*;

  logic [LW_W-1:0]  line_width_q;
  logic [TRK_W-1:0] tracking_q;
  logic [SPW_W-1:0] space_width_q;
  item_t            item;
  logic             item_valid, pop, rdy;
  res_req_t         req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= LW_W'(128);
      tracking_q    <= TRK_W'(1);
      space_width_q <= SPW_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_WIDTH:  line_width_q  <= cfg_data_i[LW_W-1:0];
        CFG_TRACKING:    tracking_q    <= cfg_data_i[TRK_W-1:0];
        CFG_SPACE_WIDTH: space_width_q <= cfg_data_i[SPW_W-1:0];
        default:         line_width_q  <= line_width_q;
      endcase
    end
  end

  gww_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .item_o       (item),
    .item_valid_o (item_valid),
    .pop_i        (pop)
  );

  gww_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .pop_o        (pop),
    .line_width_i (line_width_q),
    .tracking_i   (tracking_q),
    .space_width_i(space_width_q),
    .req_o        (req),
    .rdy_i        (rdy)
  );

  gww_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rdy_o        (rdy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
